// ===== rtl/dlmt_pkg.sv =====
// Shared types and constants of the longest-match DFA tokenizer.
// No dependencies; dlmt_oq, the top level and the testbench refer to it by scoped names.
`default_nettype none

package dlmt_pkg;

	// Operation codes of an input transaction
	localparam logic [2:0] OP_LOAD_TRANS  = 3'd0;
	localparam logic [2:0] OP_LOAD_ACCEPT = 3'd1;
	localparam logic [2:0] OP_CHAR        = 3'd2;
	localparam logic [2:0] OP_END         = 3'd3;
	localparam logic [2:0] OP_ERROR       = 3'd4;

	// Result kinds
	localparam logic [1:0] KIND_TOKEN = 2'd0;
	localparam logic [1:0] KIND_BAD   = 2'd1;
	localparam logic [1:0] KIND_END   = 2'd2;

	// Configuration register byte address
	localparam logic [2:0] ADDR_SKIP_MASK = 3'd0;

	// Location limits and the line break character
	localparam logic [19:0] LINE_MAX   = 20'hFFFFF;
	localparam logic [15:0] COL_MAX    = 16'hFFFF;
	localparam logic [7:0]  CH_NEWLINE = 8'h0A;

	typedef struct packed {
		logic [2:0]  op;
		logic [5:0]  table_state;
		logic [7:0]  table_char;
		logic [6:0]  table_next;
		logic [15:0] accept_mask;
		logic [7:0]  ch;
	} req_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [15:0] tags;
		logic [19:0] start_line;
		logic [15:0] start_column;
		logic [5:0]  length;
		logic        last;
	} rsp_t;

	// Control from the sequencer to the result queue
	typedef struct packed {
		logic push;
		logic flush;
	} oq_ctl_t;

endpackage

`default_nettype wire

// ===== rtl/dlmt_tbl.sv =====
// DFA tables: transition memory and per-state accept tag memory.
// Synchronous memories with registered read data; uses no package items.
`default_nettype none

module dlmt_tbl #(
	parameter int NUM_STATES = 64,
	parameter int ALPHABET   = 256
) (
	input  logic                          clk,
	input  logic                          tw_en,
	input  logic [$clog2(NUM_STATES)-1:0] tw_state,
	input  logic [7:0]                    tw_char,
	input  logic [6:0]                    tw_next,
	input  logic                          tr_en,
	input  logic [$clog2(NUM_STATES)-1:0] tr_state,
	input  logic [7:0]                    tr_char,
	output logic [6:0]                    tr_data,
	input  logic                          aw_en,
	input  logic [$clog2(NUM_STATES)-1:0] aw_state,
	input  logic [15:0]                   aw_mask,
	input  logic                          ar_en,
	input  logic [$clog2(NUM_STATES)-1:0] ar_state,
	output logic [15:0]                   ar_data
);

	localparam int TD = NUM_STATES * ALPHABET;
	localparam int TA = $clog2(TD);

	logic [6:0]    trans_mem [TD];
	logic [15:0]   acc_mem [NUM_STATES];
	logic [TA-1:0] tw_addr;
	logic [TA-1:0] tr_addr;

	// Flatten state and character into one row-major address
	assign tw_addr = TA'(tw_state) * TA'(ALPHABET) + TA'(tw_char);
	assign tr_addr = TA'(tr_state) * TA'(ALPHABET) + TA'(tr_char);

	// Transition memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (tw_en) begin
			trans_mem[tw_addr] <= tw_next;
		end
		if (tr_en) begin
			tr_data <= trans_mem[tr_addr];
		end
	end

	// Accept tag memory
	always_ff @(posedge clk) begin
		if (aw_en) begin
			acc_mem[aw_state] <= aw_mask;
		end
		if (ar_en) begin
			ar_data <= acc_mem[ar_state];
		end
	end

endmodule

`default_nettype wire

// ===== rtl/dlmt_buf.sv =====
// Character buffer of the token being scanned, kept as a ring by the caller.
// Synchronous memory with registered read data; uses no package items.
`default_nettype none

module dlmt_buf #(
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_idx,
	input  logic [7:0]               wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_idx,
	output logic [7:0]               rd_data
);

	logic [7:0] mem [DEPTH];

	// Write one character, read one character
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_idx] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_idx];
		end
	end

endmodule

`default_nettype wire

// ===== rtl/dlmt_oq.sv =====
// Result queue: one pending slot that waits to learn whether it is the
// final result of its item, then an output register. Depends on dlmt_pkg.
`default_nettype none

module dlmt_oq (
	input  logic             clk,
	input  logic             arst_n,
	input  dlmt_pkg::oq_ctl_t ctl,
	input  dlmt_pkg::rsp_t   push_data,
	output logic             room,
	output logic             rsp_valid,
	input  logic             rsp_stall,
	output dlmt_pkg::rsp_t   rsp
);

	dlmt_pkg::rsp_t pend_q;
	dlmt_pkg::rsp_t out_q;
	dlmt_pkg::rsp_t out_d;
	logic           pend_v_q;
	logic           out_v_q;
	logic           out_free;
	logic           move;

	assign out_free  = !out_v_q || !rsp_stall;
	assign room      = !pend_v_q || out_free;
	assign move      = pend_v_q && (ctl.push || ctl.flush);
	assign rsp_valid = out_v_q;
	assign rsp       = out_q;

	// Mark the pending result final on a flush
	always_comb begin
		out_d      = pend_q;
		out_d.last = ctl.flush;
	end

	// Advance the valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_v_q <= 1'b0;
			out_v_q  <= 1'b0;
		end else begin
			if (move) begin
				out_v_q <= 1'b1;
			end else if (!rsp_stall) begin
				out_v_q <= 1'b0;
			end
			if (ctl.push) begin
				pend_v_q <= 1'b1;
			end else if (ctl.flush) begin
				pend_v_q <= 1'b0;
			end
		end
	end

	// Move the pending result out
	always_ff @(posedge clk) begin
		if (move) begin
			out_q <= out_d;
		end
		if (ctl.push) begin
			pend_q <= push_data;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/dfa_longest_match_tokenizer_top.sv =====
// Longest-match DFA tokenizer: top level with the scan sequencer.
// Depends on dlmt_pkg, dlmt_tbl, dlmt_buf and dlmt_oq.
`default_nettype none

// Load transactions leave the sequencer idle, so the next transaction can be
// taken straight after one. Every character the DFA looks at goes through a
// buffer read, a transition memory read, an accept memory read and the match
// update when it has a transition; a character with no transition skips the
// match update, the emit taking the place of the accept read. A character that
// arrives is scanned once, and the characters after the last accepting point
// are scanned again after each token, at the same cost. A result waits while
// the output is stalled with a result already held. The next transaction is
// taken once the current one has pushed its final result. The tables are not
// cleared after reset: load every entry that the input can reach before
// sending text.
module dfa_longest_match_tokenizer_top #(
	parameter int NUM_STATES   = 64,
	parameter int ALPHABET     = 256,
	parameter int BUFFER_DEPTH = 32
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           psel,
	input  logic           penable,
	input  logic           pwrite,
	input  logic [2:0]     paddr,
	input  logic [31:0]    pwdata,
	output logic [31:0]    prdata,
	output logic           pready,
	input  logic           req_valid,
	output logic           req_stall,
	input  dlmt_pkg::req_t req,
	output logic           rsp_valid,
	input  logic           rsp_stall,
	output dlmt_pkg::rsp_t rsp
);

	localparam int SW = $clog2(NUM_STATES);
	localparam int IW = $clog2(BUFFER_DEPTH);
	localparam int BW = $clog2(BUFFER_DEPTH + 1);

	typedef enum logic [8:0] {
		S_IDLE = 9'b000000001,
		S_CHAR = 9'b000000010,
		S_EOF  = 9'b000000100,
		S_ERR  = 9'b000001000,
		S_RD   = 9'b000010000,
		S_CH   = 9'b000100000,
		S_NX   = 9'b001000000,
		S_AM   = 9'b010000000,
		S_FIN  = 9'b100000000
	} st_t;

	st_t st_q, st_d;
	logic [2:0]    op_q, op_d;
	logic          app_q, app_d;
	logic          wide_q, wide_d;
	logic [7:0]    ch_q, ch_d;
	logic [IW-1:0] head_q, head_d;
	logic [BW-1:0] fill_q, fill_d;
	logic [BW-1:0] pos_q, pos_d;
	logic [SW-1:0] dfa_q, dfa_d;
	logic          have_q, have_d;
	logic [15:0]   mtags_q, mtags_d;
	logic [BW-1:0] mlen_q, mlen_d;
	logic [19:0]   cur_line_q, cur_line_d;
	logic [15:0]   cur_col_q, cur_col_d;
	logic [19:0]   tok_line_q, tok_line_d;
	logic [15:0]   tok_col_q, tok_col_d;
	logic [19:0]   mend_line_q, mend_line_d;
	logic [15:0]   mend_col_q, mend_col_d;
	logic [15:0]   skip_q;

	logic          accept;
	logic          cfg_wr;
	logic          tw_en;
	logic          aw_en;
	logic          tr_en;
	logic          ar_en;
	logic [6:0]    tr_data;
	logic [15:0]   ar_data;
	logic          buf_wr_en;
	logic          buf_rd_en;
	logic [IW-1:0] buf_wr_idx;
	logic [IW-1:0] buf_rd_idx;
	logic [7:0]    buf_rd_data;
	logic          nx_ok;

	logic          em_go;
	logic          em_match;
	logic [BW-1:0] em_badlen;
	logic          end_go;
	logic          rs_go;
	logic          hold;
	logic [BW-1:0] drop;
	logic          oq_room;
	dlmt_pkg::oq_ctl_t oq_ctl;
	dlmt_pkg::rsp_t    rs_data;

	// Ring index: base plus offset, wrapped once at the buffer depth
	function automatic logic [IW-1:0] ring(input logic [IW-1:0] base,
			input logic [BW-1:0] off);
		logic [BW:0] s;
		s = (BW+1)'(base) + (BW+1)'(off);
		if (s >= (BW+1)'(BUFFER_DEPTH)) begin
			s = s - (BW+1)'(BUFFER_DEPTH);
		end
		return IW'(s);
	endfunction

	// Configuration port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && (paddr == dlmt_pkg::ADDR_SKIP_MASK);
	assign prdata = (paddr == dlmt_pkg::ADDR_SKIP_MASK) ? {16'h0000, skip_q} : 32'h0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skip_q <= 16'h0000;
		end else if (cfg_wr) begin
			skip_q <= pwdata[15:0];
		end
	end

	// Input handshake and table loads
	assign req_stall = (st_q != S_IDLE);
	assign accept    = req_valid && !req_stall;
	assign tw_en = accept && (req.op == dlmt_pkg::OP_LOAD_TRANS)
		&& (32'(req.table_state) < NUM_STATES) && (32'(req.table_char) < ALPHABET);
	assign aw_en = accept && (req.op == dlmt_pkg::OP_LOAD_ACCEPT)
		&& (32'(req.table_state) < NUM_STATES);

	dlmt_tbl #(
		.NUM_STATES(NUM_STATES),
		.ALPHABET  (ALPHABET)
	) u_tbl (
		.clk     (clk),
		.tw_en   (tw_en),
		.tw_state(SW'(req.table_state)),
		.tw_char (req.table_char),
		.tw_next (req.table_next),
		.tr_en   (tr_en),
		.tr_state(dfa_q),
		.tr_char (buf_rd_data),
		.tr_data (tr_data),
		.aw_en   (aw_en),
		.aw_state(SW'(req.table_state)),
		.aw_mask (req.accept_mask),
		.ar_en   (ar_en),
		.ar_state(SW'(tr_data)),
		.ar_data (ar_data)
	);

	assign buf_wr_idx = ring(head_q, fill_q);
	assign buf_rd_idx = ring(head_q, pos_q);

	dlmt_buf #(
		.DEPTH(BUFFER_DEPTH)
	) u_buf (
		.clk    (clk),
		.wr_en  (buf_wr_en),
		.wr_idx (buf_wr_idx),
		.wr_data(ch_q),
		.rd_en  (buf_rd_en),
		.rd_idx (buf_rd_idx),
		.rd_data(buf_rd_data)
	);

	dlmt_oq u_oq (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (oq_ctl),
		.push_data(rs_data),
		.room     (oq_room),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp      (rsp)
	);

	assign nx_ok = !wide_q && (32'(tr_data) < NUM_STATES);

	// Decide whether this state emits a token, a bad token or the end result
	always_comb begin
		em_go     = 1'b0;
		em_match  = have_q;
		em_badlen = fill_q;
		end_go    = 1'b0;
		unique case (st_q)
			S_CHAR: em_go = (fill_q == BW'(BUFFER_DEPTH));
			S_NX: begin
				em_go     = !nx_ok;
				em_badlen = pos_q;
			end
			S_EOF: begin
				em_go  = (fill_q != '0);
				end_go = (fill_q == '0);
			end
			S_ERR: em_go = 1'b1;
			default: em_go = 1'b0;
		endcase
	end

	// Build the result and check for room in the queue
	always_comb begin
		rs_go = end_go || (em_go && (!em_match || ((mtags_q & skip_q) == 16'h0000)));
		hold  = rs_go && !oq_room;
		drop  = em_match ? mlen_q : em_badlen;
		rs_data = '0;
		if (end_go) begin
			rs_data.kind         = dlmt_pkg::KIND_END;
			rs_data.start_line   = cur_line_q;
			rs_data.start_column = cur_col_q;
		end else if (em_match) begin
			rs_data.kind         = dlmt_pkg::KIND_TOKEN;
			rs_data.tags         = mtags_q;
			rs_data.start_line   = tok_line_q;
			rs_data.start_column = tok_col_q;
			rs_data.length       = 6'(mlen_q);
		end else begin
			rs_data.kind         = dlmt_pkg::KIND_BAD;
			rs_data.start_line   = tok_line_q;
			rs_data.start_column = tok_col_q;
			rs_data.length       = 6'(em_badlen);
		end
	end

	// Scan sequencer
	always_comb begin
		st_d        = st_q;
		op_d        = op_q;
		app_d       = app_q;
		wide_d      = wide_q;
		ch_d        = ch_q;
		head_d      = head_q;
		fill_d      = fill_q;
		pos_d       = pos_q;
		dfa_d       = dfa_q;
		have_d      = have_q;
		mtags_d     = mtags_q;
		mlen_d      = mlen_q;
		cur_line_d  = cur_line_q;
		cur_col_d   = cur_col_q;
		tok_line_d  = tok_line_q;
		tok_col_d   = tok_col_q;
		mend_line_d = mend_line_q;
		mend_col_d  = mend_col_q;
		buf_wr_en   = 1'b0;
		buf_rd_en   = 1'b0;
		tr_en       = 1'b0;
		ar_en       = 1'b0;
		oq_ctl      = '0;

		// Emit: drop the token's characters and restart from the root
		if (em_go && !hold) begin
			head_d = ring(head_q, drop);
			fill_d = fill_q - drop;
			if (em_match) begin
				cur_line_d = mend_line_q;
				cur_col_d  = mend_col_q;
				tok_line_d = mend_line_q;
				tok_col_d  = mend_col_q;
			end else begin
				tok_line_d = cur_line_q;
				tok_col_d  = cur_col_q;
			end
			pos_d   = '0;
			dfa_d   = '0;
			have_d  = 1'b0;
			mtags_d = 16'h0000;
			mlen_d  = '0;
		end
		oq_ctl.push = rs_go && !hold;

		unique case (st_q)
			S_IDLE: begin
				if (accept) begin
					op_d  = req.op;
					ch_d  = req.ch;
					app_d = 1'b0;
					priority case (req.op)
						dlmt_pkg::OP_CHAR:  st_d = S_CHAR;
						dlmt_pkg::OP_END:   st_d = S_EOF;
						dlmt_pkg::OP_ERROR: st_d = S_ERR;
						default:            st_d = S_IDLE;
					endcase
				end
			end
			S_CHAR: begin
				if (fill_q == BW'(BUFFER_DEPTH)) begin
					if (!hold) begin
						st_d = S_RD;
					end
				end else begin
					buf_wr_en = 1'b1;
					fill_d    = fill_q + 1'b1;
					app_d     = 1'b1;
					st_d      = S_RD;
				end
			end
			S_RD: begin
				if (pos_q == fill_q) begin
					priority case (op_q)
						dlmt_pkg::OP_CHAR: st_d = app_q ? S_FIN : S_CHAR;
						dlmt_pkg::OP_END:  st_d = S_EOF;
						default:           st_d = S_FIN;
					endcase
				end else begin
					buf_rd_en = 1'b1;
					st_d      = S_CH;
				end
			end
			S_CH: begin
				pos_d  = pos_q + 1'b1;
				wide_d = (32'(buf_rd_data) >= ALPHABET);
				tr_en  = (32'(buf_rd_data) < ALPHABET);
				if (buf_rd_data == dlmt_pkg::CH_NEWLINE) begin
					if (cur_line_q != dlmt_pkg::LINE_MAX) begin
						cur_line_d = cur_line_q + 1'b1;
					end
					cur_col_d = 16'd1;
				end else if (cur_col_q != dlmt_pkg::COL_MAX) begin
					cur_col_d = cur_col_q + 1'b1;
				end
				st_d = S_NX;
			end
			S_NX: begin
				if (!nx_ok) begin
					if (!hold) begin
						st_d = S_RD;
					end
				end else begin
					dfa_d = SW'(tr_data);
					ar_en = 1'b1;
					st_d  = S_AM;
				end
			end
			S_AM: begin
				if (ar_data != 16'h0000) begin
					have_d      = 1'b1;
					mtags_d     = ar_data;
					mlen_d      = pos_q;
					mend_line_d = cur_line_q;
					mend_col_d  = cur_col_q;
				end
				st_d = S_RD;
			end
			S_EOF: begin
				if (!hold) begin
					if (fill_q == '0) begin
						st_d = S_FIN;
					end else begin
						st_d = have_q ? S_RD : S_EOF;
					end
				end
			end
			S_ERR: begin
				if (!hold) begin
					st_d = have_q ? S_RD : S_FIN;
				end
			end
			S_FIN: begin
				if (oq_room) begin
					oq_ctl.flush = 1'b1;
					st_d         = S_IDLE;
				end
			end
			default: st_d = S_IDLE;
		endcase
	end

	// Hold the scan state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= S_IDLE;
			op_q        <= dlmt_pkg::OP_LOAD_TRANS;
			app_q       <= 1'b0;
			wide_q      <= 1'b0;
			head_q      <= '0;
			fill_q      <= '0;
			pos_q       <= '0;
			dfa_q       <= '0;
			have_q      <= 1'b0;
			mtags_q     <= 16'h0000;
			mlen_q      <= '0;
			cur_line_q  <= 20'd1;
			cur_col_q   <= 16'd1;
			tok_line_q  <= 20'd1;
			tok_col_q   <= 16'd1;
			mend_line_q <= 20'd1;
			mend_col_q  <= 16'd1;
		end else begin
			st_q        <= st_d;
			op_q        <= op_d;
			app_q       <= app_d;
			wide_q      <= wide_d;
			head_q      <= head_d;
			fill_q      <= fill_d;
			pos_q       <= pos_d;
			dfa_q       <= dfa_d;
			have_q      <= have_d;
			mtags_q     <= mtags_d;
			mlen_q      <= mlen_d;
			cur_line_q  <= cur_line_d;
			cur_col_q   <= cur_col_d;
			tok_line_q  <= tok_line_d;
			tok_col_q   <= tok_col_d;
			mend_line_q <= mend_line_d;
			mend_col_q  <= mend_col_d;
		end
	end

	// Character of the current transaction
	always_ff @(posedge clk) begin
		ch_q <= ch_d;
	end

	// Scan position never passes the fill, and the fill never passes the depth
	a_fill_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		(pos_q <= fill_q) && (fill_q <= BW'(BUFFER_DEPTH)))
		else $error("scan position or buffer fill out of range");

	// Between transactions every buffered character has been scanned
	a_idle_scanned: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == S_IDLE) |-> (pos_q == fill_q))
		else $error("idle with unscanned characters");

	// A remembered match is non-empty and lies within the scanned part
	a_match_len: assert property (@(posedge clk) disable iff (!arst_n)
		have_q |-> ((mlen_q != '0) && (mlen_q <= pos_q)))
		else $error("match length inconsistent with scan position");

endmodule

`default_nettype wire

// ===== bench/dfa_longest_match_tokenizer_top_tb.sv =====
// Self-checking testbench for the longest-match DFA tokenizer top level.
// Depends on dlmt_pkg and dfa_longest_match_tokenizer_top; the scoreboard
// predicts tokens from the loaded tables and checks every result transaction.
`default_nettype none

module dfa_longest_match_tokenizer_top_tb;

	localparam int N_STATES = 64;
	localparam int DEPTH    = 32;
	localparam int N_CHARS  = 7;

	// Token predictor and store of expected results
	class tokenizer_scoreboard;
		logic [6:0]  trans_mem [N_STATES*256];
		logic [15:0] accept_mem [N_STATES];
		logic [7:0]  pending [$];
		dlmt_pkg::rsp_t expected [$];
		int          scan_pos, match_len;
		int          cur_ln, cur_col, tok_ln, tok_col, end_ln, end_col;
		logic [5:0]  dstate;
		bit          have_m;
		logic [15:0] match_tags, skip;
		int          errors;

		function new();
			scan_pos = 0; dstate = 0; have_m = 0; match_tags = 0; match_len = 0;
			cur_ln = 1; cur_col = 1; tok_ln = 1; tok_col = 1; end_ln = 1; end_col = 1;
			skip = 0; errors = 0;
		endfunction

		function void push_token(logic [1:0] k, logic [15:0] t, int ln, int col, int len);
			dlmt_pkg::rsp_t r;
			r.kind = k; r.tags = t; r.start_line = ln[19:0]; r.start_column = col[15:0];
			r.length = len[5:0]; r.last = 1'b0;
			expected.insert(expected.size(), r);
		endfunction

		function void restart();
			scan_pos = 0; dstate = 0; have_m = 0; match_tags = 0; match_len = 0;
		endfunction

		function void drop_front(int n);
			repeat (n) if (pending.size() > 0) void'(pending.pop_front());
		endfunction

		function void give_match();
			if ((match_tags & skip) == 0)
				push_token(dlmt_pkg::KIND_TOKEN, match_tags, tok_ln, tok_col, match_len);
			drop_front(match_len);
			cur_ln = end_ln; cur_col = end_col; tok_ln = cur_ln; tok_col = cur_col;
			restart();
		endfunction

		function void give_bad(int n);
			push_token(dlmt_pkg::KIND_BAD, 16'h0, tok_ln, tok_col, n);
			drop_front(n);
			tok_ln = cur_ln; tok_col = cur_col;
			restart();
		endfunction

		// Run the DFA over buffered characters, backtracking on failure
		function void scan();
			logic [7:0] c;
			logic [6:0] nx;
			while (scan_pos < pending.size()) begin
				c = pending[scan_pos];
				scan_pos++;
				if (c == dlmt_pkg::CH_NEWLINE) begin
					if (cur_ln < dlmt_pkg::LINE_MAX) cur_ln++;
					cur_col = 1;
				end else if (cur_col < dlmt_pkg::COL_MAX) begin
					cur_col++;
				end
				nx = trans_mem[{dstate, c}];
				if (nx >= N_STATES) begin
					if (have_m) give_match();
					else give_bad(scan_pos);
					continue;
				end
				dstate = nx[5:0];
				if (accept_mem[dstate] != 0) begin
					have_m = 1; match_tags = accept_mem[dstate]; match_len = scan_pos;
					end_ln = cur_ln; end_col = cur_col;
				end
			end
		endfunction

		function void note_item(dlmt_pkg::req_t r);
			int prior_count;
			prior_count = expected.size();
			case (r.op)
				dlmt_pkg::OP_LOAD_TRANS:
					trans_mem[{r.table_state, r.table_char}] = r.table_next;
				dlmt_pkg::OP_LOAD_ACCEPT: accept_mem[r.table_state] = r.accept_mask;
				dlmt_pkg::OP_CHAR: begin
					if (pending.size() >= DEPTH) begin
						if (have_m) give_match();
						else give_bad(pending.size());
						scan();
					end
					if (pending.size() < DEPTH) pending.insert(pending.size(), r.ch);
					scan();
				end
				dlmt_pkg::OP_END: begin
					while (pending.size() > 0) begin
						if (have_m) begin
							give_match();
							scan();
						end else begin
							give_bad(pending.size());
						end
					end
					push_token(dlmt_pkg::KIND_END, 16'h0, cur_ln, cur_col, 0);
				end
				dlmt_pkg::OP_ERROR: begin
					if (have_m) begin
						give_match();
						scan();
					end else begin
						give_bad(pending.size());
					end
				end
				default: ;
			endcase
			if (expected.size() > prior_count) expected[$].last = 1'b1;
		endfunction

		function void check_token(dlmt_pkg::rsp_t a);
			dlmt_pkg::rsp_t e;
			if (expected.size() == 0) begin
				$display("%0t: unexpected result, expected none, got %p", $time, a);
				errors++;
				return;
			end
			e = expected.pop_front();
			if (a !== e) begin
				$display("%0t: result mismatch, expected %p, got %p", $time, e, a);
				errors++;
			end
		endfunction
	endclass

	logic        clk, arst_n;
	logic        psel, penable, pwrite, pready;
	logic [2:0]  paddr;
	logic [31:0] pwdata, prdata;
	logic        req_valid, req_stall, rsp_valid, rsp_stall;
	dlmt_pkg::req_t req;
	dlmt_pkg::rsp_t rsp;

	tokenizer_scoreboard sb;
	logic [7:0] charset [N_CHARS] = '{8'h00, dlmt_pkg::CH_NEWLINE, 8'h41, 8'h42, 8'h55,
		8'hAA, 8'hFF};
	logic [5:0] dfa_states [4] = '{6'd0, 6'd1, 6'd2, 6'd63};
	bit send_burst, recv_burst;
	int tokens_seen;

	dfa_longest_match_tokenizer_top dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.req_valid(req_valid), .req_stall(req_stall), .req(req),
		.rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp)
	);

	always begin
		clk = 1'b1; #1;
		clk = 1'b0; #1;
	end

	// Hold the transaction until taken, then idle for a drawn gap
	task automatic send_item(dlmt_pkg::req_t r);
		int gap;
		req <= r;
		req_valid <= 1'b1;
		do @(posedge clk); while (req_stall);
		sb.note_item(r);
		gap = send_burst ? 0 : $urandom_range(0, 17);
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	function automatic dlmt_pkg::req_t noise_item();
		dlmt_pkg::req_t r;
		r = dlmt_pkg::req_t'(48'({$urandom, $urandom}));
		return r;
	endfunction

	task automatic send_op(logic [2:0] op, logic [7:0] c);
		dlmt_pkg::req_t r;
		r = noise_item();
		r.op = op; r.ch = c;
		send_item(r);
	endtask

	task automatic load_trans(logic [5:0] s, logic [7:0] c, logic [6:0] nx);
		dlmt_pkg::req_t r;
		r = noise_item();
		r.op = dlmt_pkg::OP_LOAD_TRANS; r.table_state = s; r.table_char = c;
		r.table_next = nx;
		send_item(r);
	endtask

	task automatic load_accept(logic [5:0] s, logic [15:0] m);
		dlmt_pkg::req_t r;
		r = noise_item();
		r.op = dlmt_pkg::OP_LOAD_ACCEPT; r.table_state = s; r.accept_mask = m;
		send_item(r);
	endtask

	// Random DFA over states 0, 1, 2 and 63 and the test character set
	task automatic load_random_dfa();
		logic [6:0] targets [6] = '{7'd0, 7'd1, 7'd2, 7'd63, 7'd64, 7'd64};
		foreach (dfa_states[i]) begin
			load_accept(dfa_states[i], ($urandom_range(0, 1) != 0) ? 16'($urandom) : 16'h0);
			foreach (charset[j])
				load_trans(dfa_states[i], charset[j], targets[$urandom_range(0, 5)]);
		end
	endtask

	task automatic write_skip(logic [15:0] m);
		@(posedge clk);
		psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= dlmt_pkg::ADDR_SKIP_MASK;
		pwdata <= {16'h0, m};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
		sb.skip = m;
	endtask

	task automatic wait_drained();
		req_valid <= 1'b0;
		while (sb.expected.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic random_text(int n, bit pause_midway);
		int pick;
		for (int i = 0; i < n; i++) begin
			if (pause_midway && i == n / 2) begin
				req_valid <= 1'b0;
				while (sb.expected.size() != 0) @(posedge clk);
			end
			if (i % 20 == 0) send_burst = $urandom_range(0, 2) == 0;
			pick = $urandom_range(0, 99);
			if (pick < 82) send_op(dlmt_pkg::OP_CHAR, charset[$urandom_range(0, N_CHARS - 1)]);
			else if (pick < 89) send_op(dlmt_pkg::OP_END, 8'h0);
			else if (pick < 96) send_op(dlmt_pkg::OP_ERROR, 8'h0);
			else send_op(3'($urandom_range(5, 7)), 8'h0);
		end
	endtask

	// Receiver: check each taken result, draw stalls, one long hold-off
	initial begin
		int hold;
		hold = 0;
		rsp_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (rsp_valid && !rsp_stall) begin
				sb.check_token(rsp);
				tokens_seen++;
				if (tokens_seen % 25 == 0) recv_burst = $urandom_range(0, 2) == 0;
				hold = recv_burst ? 0 : $urandom_range(0, 17);
				if (tokens_seen == 12) hold = 500;
			end
			if (hold > 0) begin
				hold--;
				rsp_stall <= 1'b1;
			end else begin
				rsp_stall <= 1'b0;
			end
		end
	end

	initial begin
		#5_000_000;
		$display("dfa_longest_match_tokenizer_top_tb: FAIL");
		$finish;
	end

	initial begin
		sb = new();
		tokens_seen = 0;
		send_burst = 0; recv_burst = 0;
		arst_n = 1'b0;
		psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
		req_valid = 1'b0; req = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		write_skip(16'h0);

		// Directed table: A+ accepts tag 0, B+ dead-ends unless an A follows,
		// newline alone accepts tag 15
		foreach (dfa_states[i]) foreach (charset[j]) load_trans(dfa_states[i], charset[j], 7'd64);
		load_accept(6'd0, 16'h0); load_accept(6'd1, 16'h0001);
		load_accept(6'd2, 16'h0); load_accept(6'd63, 16'h8000);
		load_trans(6'd0, 8'h41, 7'd1); load_trans(6'd0, 8'h42, 7'd2);
		load_trans(6'd0, dlmt_pkg::CH_NEWLINE, 7'd63); load_trans(6'd1, 8'h41, 7'd1);
		load_trans(6'd2, 8'h42, 7'd2); load_trans(6'd2, 8'h41, 7'd1);

		send_op(dlmt_pkg::OP_ERROR, 8'h0);        // read error on empty buffer
		send_op(dlmt_pkg::OP_CHAR, 8'h41); send_op(dlmt_pkg::OP_CHAR, 8'h41);
		send_op(dlmt_pkg::OP_CHAR, 8'h42);        // longest match then rescan
		send_op(dlmt_pkg::OP_CHAR, 8'h42); send_op(dlmt_pkg::OP_CHAR, 8'h41);
		send_op(dlmt_pkg::OP_CHAR, 8'hFF);        // match ends, no transition
		send_op(dlmt_pkg::OP_CHAR, dlmt_pkg::CH_NEWLINE);
		send_op(dlmt_pkg::OP_CHAR, 8'h42); send_op(dlmt_pkg::OP_CHAR, 8'h00); // no match
		send_op(dlmt_pkg::OP_CHAR, 8'h41);
		send_op(dlmt_pkg::OP_ERROR, 8'h0);        // read error with pending match
		send_op(3'd5, 8'h0); send_op(3'd7, 8'h0);
		send_op(dlmt_pkg::OP_END, 8'h0); send_op(dlmt_pkg::OP_END, 8'h0);
		repeat (34) send_op(dlmt_pkg::OP_CHAR, 8'h41); // buffer full with a match
		repeat (34) send_op(dlmt_pkg::OP_CHAR, 8'h42); // buffer full without a match
		send_op(dlmt_pkg::OP_END, 8'h0);
		wait_drained();
		write_skip(16'hFFFF);
		send_op(dlmt_pkg::OP_CHAR, 8'h41); send_op(dlmt_pkg::OP_CHAR, dlmt_pkg::CH_NEWLINE);
		send_op(dlmt_pkg::OP_END, 8'h0);

		// Random phase with a fresh table and skip setting
		wait_drained();
		write_skip(16'($urandom) & 16'($urandom));
		load_random_dfa();
		random_text(20, 1'b1);
		send_op(dlmt_pkg::OP_END, 8'h0);

		wait_drained();
		if (sb.expected.size() != 0) sb.errors++;
		if (sb.errors == 0) begin
			$display("dfa_longest_match_tokenizer_top_tb: PASS");
		end else begin
			$display("dfa_longest_match_tokenizer_top_tb: FAIL");
		end
		$finish;
	end

endmodule

`default_nettype wire
